>>> src/dfr_pkg.sv
// Shared types and constants for the sync-word frame deframer.
// No dependencies; imported by the top level, the front and the back.
`default_nettype none
package dfr_pkg;

  localparam int FRAME_WORDS = 256;
  localparam int WIN_BYTES   = 2 * FRAME_WORDS;
  localparam int WIN_AW      = $clog2(WIN_BYTES);
  localparam int FILL_W      = WIN_AW + 1;
  localparam int FS_AW       = $clog2(FRAME_WORDS);
  localparam int CNT_W       = FS_AW + 1;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = QAW + 1;

  localparam logic [15:0] HEAD_WORD0 = 16'h00AB;
  localparam logic [15:0] HEAD_WORD1 = 16'h00CD;
  localparam logic [15:0] TAIL_WORD0 = 16'h00DC;
  localparam logic [15:0] TAIL_WORD1 = 16'h00BA;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_READ = 1'b1;
  localparam logic RES_FRAME = 1'b0;
  localparam logic RES_READ  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] serial_byte;
    logic [7:0] read_index;
  } item_t;

endpackage
`default_nettype wire

>>> src/sync_word_frame_deframer_core.sv
// Top level of the sync-word frame deframer: input queue front and execution back.
// Depends on dfr_pkg, dfr_front and dfr_back.
//
//  channel | dir | tdata                          | tuser
//  s_*     | in  | serial_byte, read_index        | kind
//  m_*     | out | first_frame, data_changed,     | result_kind
//          |     | frame_checksum, read_word      |
//
// A byte that leaves the window short of full is done in idle; a full window that
// fails the check enters a refill state (last head byte from the window memory).
// A read passes through a wait state (registered frame store read).
// An accepted frame starts the sweep: the copy into the frame store
// issues one word per cycle over the two window read ports, then the last word
// lands in the frame store and the block returns to idle.
// Reset is synchronous; memories are not cleared. The 4-entry queue keeps
// accepting while the output register is stalled, until it is full.
`default_nettype none
module sync_word_frame_deframer_core
  import dfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // [7:0] serial_byte, [15:8] read_index
  input  wire logic        s_tuser,  // [0] kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,  // [0] first_frame, [1] data_changed,
                                     // [17:2] frame_checksum, [33:18] read_word
  output logic             m_tuser   // [0] result_kind
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  dfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  dfr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire

>>> src/dfr_front.sv
// Input side: accepts stream transfers, unpacks them into items and queues them.
// Depends on dfr_pkg.
`default_nettype none
module dfr_front
  import dfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,
  input  wire logic        s_tuser,
  output logic             q_valid,
  output item_t            q_item,
  input  wire logic        q_pop
);

  item_t            slots [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;
  logic             push;

  assign s_tready = (count != QCW'(QDEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{kind: s_tuser, serial_byte: s_tdata[7:0],
                         read_index: s_tdata[15:8]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QAW'(1);
      if (q_pop) rd_ptr <= rd_ptr + QAW'(1);
      if (push && !q_pop) count <= count + QCW'(1);
      else if (!push && q_pop) count <= count - QCW'(1);
    end
  end

endmodule
`default_nettype wire

>>> src/dfr_back.sv
// Execution side: byte window, frame check, frame store copy and read replies.
// Depends on dfr_pkg; holds the window and frame store memories and the output register.
`default_nettype none
module dfr_back
  import dfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  item_t            q_item,
  output logic             q_pop,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,
  output logic             m_tuser
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_REFILL = 2'd1;
  localparam logic [1:0] S_RDWAIT = 2'd2;
  localparam logic [1:0] S_SWEEP  = 2'd3;

  logic [1:0]        st;
  logic [7:0]        win [WIN_BYTES];
  logic [15:0]       fstore [FRAME_WORDS];

  logic [FILL_W-1:0] fill;
  logic [WIN_AW-1:0] start;
  logic [7:0]        xe;
  logic [7:0]        xo;
  logic [7:0]        head [4];
  logic [7:0]        tail [6];
  logic              seen;
  logic [15:0]       last_chk;

  logic [WIN_AW-1:0] sweep_base;
  logic [CNT_W-1:0]  cnt;
  logic              wr_pend;
  logic [FS_AW-1:0]  wr_k;
  logic [7:0]        qa;
  logic [7:0]        qb;
  logic [15:0]       fs_q;
  logic              idx_ok;

  logic              out_valid;
  logic              out_kind;
  logic              out_first;
  logic              out_changed;
  logic [15:0]       out_chk;
  logic [15:0]       out_word;

  logic              out_free;
  logic              pop_byte;
  logic              pop_read;
  logic [WIN_AW-1:0] wr_addr;
  logic [WIN_AW-1:0] ra;
  logic [WIN_AW-1:0] rb;
  logic [7:0]        b;
  logic [7:0]        even_n;
  logic [7:0]        odd_n;
  logic [7:0]        head_n [4];
  logic [7:0]        tail_n [6];
  logic              full_n;
  logic [15:0]       h0, h1, chk, f0, f1, calc;
  logic              match;
  logic              issue;
  logic [FS_AW-1:0]  rd_addr;

  assign out_free = !out_valid || m_tready;
  assign q_pop    = (st == S_IDLE) && q_valid && out_free;
  assign pop_byte = q_pop && (q_item.kind == KIND_BYTE);
  assign pop_read = q_pop && (q_item.kind == KIND_READ);
  assign b        = q_item.serial_byte;
  assign wr_addr  = start + fill[WIN_AW-1:0];
  assign issue    = (st == S_SWEEP) && (cnt < CNT_W'(FRAME_WORDS));
  assign rd_addr  = FS_AW'(q_item.read_index);

  always_comb begin
    even_n = fill[0] ? xe : (xe ^ b);
    odd_n  = fill[0] ? (xo ^ b) : xo;
    for (int i = 0; i < 4; i++) begin
      head_n[i] = head[i];
    end
    if (fill < FILL_W'(4)) head_n[fill[1:0]] = b;
    for (int i = 0; i < 5; i++) begin
      tail_n[i] = tail[i + 1];
    end
    tail_n[5] = b;
    full_n = (fill == FILL_W'(WIN_BYTES - 1));
    h0     = {head_n[0], head_n[1]};
    h1     = {head_n[2], head_n[3]};
    chk    = {tail_n[0], tail_n[1]};
    f0     = {tail_n[2], tail_n[3]};
    f1     = {tail_n[4], tail_n[5]};
    calc   = {even_n, odd_n} ^ chk ^ f0 ^ f1;
    match  = (h0 == HEAD_WORD0) && (h1 == HEAD_WORD1) && (f0 == TAIL_WORD0) &&
             (f1 == TAIL_WORD1) && (calc == chk);
    if (st == S_SWEEP) begin
      ra = sweep_base + {cnt[FS_AW-1:0], 1'b0};
    end else begin
      ra = start + WIN_AW'(4);
    end
    rb = ra + WIN_AW'(1);
  end

  // window memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (pop_byte) win[wr_addr] <= b;
    qa <= win[ra];
    qb <= win[rb];
  end

  // frame store: copy sweep writes, read replies read
  always_ff @(posedge clk) begin
    if (wr_pend) fstore[wr_k] <= {qa, qb};
    fs_q <= fstore[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pop_byte) begin
      tail <= tail_n;
      if (full_n && !match) begin
        head[0] <= head_n[1];
        head[1] <= head_n[2];
        head[2] <= head_n[3];
      end else begin
        head <= head_n;
      end
    end
    if (st == S_REFILL) head[3] <= qa;
    if (pop_read) idx_ok <= (32'(q_item.read_index) < FRAME_WORDS);
    if (issue) wr_k <= cnt[FS_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      fill      <= '0;
      start     <= '0;
      xe        <= '0;
      xo        <= '0;
      seen      <= 1'b0;
      cnt       <= '0;
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      wr_pend <= issue;
      if (out_valid && m_tready) out_valid <= 1'b0;
      case (st)
        S_IDLE: begin
          if (pop_read) begin
            st <= S_RDWAIT;
          end else if (pop_byte) begin
            if (!full_n) begin
              fill <= fill + FILL_W'(1);
              xe   <= even_n;
              xo   <= odd_n;
            end else if (match) begin
              out_valid   <= 1'b1;
              out_kind    <= RES_FRAME;
              out_first   <= !seen;
              out_changed <= seen && (last_chk != chk);
              out_chk     <= chk;
              out_word    <= '0;
              last_chk    <= chk;
              seen        <= 1'b1;
              sweep_base  <= start;
              fill        <= '0;
              start       <= '0;
              xe          <= '0;
              xo          <= '0;
              cnt         <= '0;
              st          <= S_SWEEP;
            end else begin
              // drop the oldest byte; remaining bytes swap parity
              xe    <= odd_n;
              xo    <= even_n ^ head_n[0];
              start <= start + WIN_AW'(1);
              st    <= S_REFILL;
            end
          end
        end
        S_REFILL: begin
          st <= S_IDLE;
        end
        S_RDWAIT: begin
          out_valid   <= 1'b1;
          out_kind    <= RES_READ;
          out_first   <= 1'b0;
          out_changed <= 1'b0;
          out_chk     <= '0;
          out_word    <= idx_ok ? fs_q : 16'd0;
          st          <= S_IDLE;
        end
        S_SWEEP: begin
          if (issue) begin
            cnt <= cnt + CNT_W'(1);
          end else if (!wr_pend) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {6'd0, out_word, out_chk, out_changed, out_first};

endmodule
`default_nettype wire

>>> src/dfr_checker.sv
// Port-level checks for the deframer top level, attached by bind.
// No dependencies beyond the top level's ports.
`default_nettype none
module dfr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic        m_tuser
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output transfer dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("output payload changed while stalled");

  a_read_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[17:0] == 18'd0)
    else $error("read reply carries frame report fields");

  a_report_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[39:18] == 22'd0)
    else $error("frame report carries read data");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind sync_word_frame_deframer_core dfr_checker u_dfr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

>>> test/tb_top.sv
// Self-checking bench for sync_word_frame_deframer_core: streams serial bytes and
// read requests, predicts frame reports and read replies, checks every result.
// Depends on dfr_pkg and the deframer RTL.
`timescale 1ns / 100ps
module tb_top;
  import dfr_pkg::*;

  typedef struct {
    logic       drain;   // hold off until every expected result has arrived
    logic       kind;
    logic [7:0] sbyte;
    logic [7:0] ridx;
  } stim_t;

  typedef struct {
    logic        rkind;
    logic        first;
    logic        changed;
    logic [15:0] chk;
    logic [15:0] rword;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;

  sync_word_frame_deframer_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial forever #1 clk = ~clk;

  stim_t  pending_q[$];
  reply_t reply_q[$];

  // predictor state
  logic [7:0]  win_q[$];
  logic [15:0] store_words[FRAME_WORDS];
  logic        have_frame = 1'b0;

  int errors = 0;
  int n_frames_seen = 0;
  int n_reads_seen = 0;
  int n_sent = 0;
  int idle_cycles = 0;
  logic idle_en = 1'b1;

  function automatic logic [15:0] win_word(int k);
    return {win_q[2*k], win_q[2*k+1]};
  endfunction

  task automatic deframe_predict(stim_t it);
    reply_t r;
    logic [15:0] acc;
    r = '{rkind: RES_READ, first: 1'b0, changed: 1'b0, chk: 16'h0, rword: 16'h0};
    if (it.kind == KIND_READ) begin
      r.rword = store_words[it.ridx];
      reply_q.push_back(r);
    end else begin
      win_q.push_back(it.sbyte);
      if (win_q.size() == WIN_BYTES) begin
        acc = 16'h0;
        for (int k = 0; k < FRAME_WORDS - 3; k++) acc ^= win_word(k);
        if (win_word(0) == HEAD_WORD0 && win_word(1) == HEAD_WORD1 &&
            win_word(FRAME_WORDS-2) == TAIL_WORD0 &&
            win_word(FRAME_WORDS-1) == TAIL_WORD1 &&
            acc == win_word(FRAME_WORDS-3)) begin
          r.rkind   = RES_FRAME;
          r.first   = !have_frame;
          r.changed = have_frame && store_words[FRAME_WORDS-3] != acc;
          r.chk     = acc;
          for (int k = 0; k < FRAME_WORDS; k++) store_words[k] = win_word(k);
          have_frame = 1'b1;
          win_q.delete();
          reply_q.push_back(r);
        end else begin
          void'(win_q.pop_front());
        end
      end
    end
  endtask

  // sender
  int gap_left = 0;
  always @(posedge clk) begin
    logic  nvalid;
    stim_t it;
    nvalid = s_tvalid;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        n_sent++;
        nvalid = 1'b0;
        gap_left = idle_en ? $urandom_range(0, 4) : 0;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          if (pending_q[0].drain) begin
            if (reply_q.size() == 0) void'(pending_q.pop_front());
          end else begin
            it = pending_q.pop_front();
            deframe_predict(it);
            s_tdata <= {it.ridx, it.sbyte};
            s_tuser <= it.kind;
            nvalid = 1'b1;
          end
        end
      end
    end
    s_tvalid <= nvalid;
  end

  // receiver
  int stall_left = 0;
  int hold_left = 0;
  logic held = 1'b0;
  always @(posedge clk) begin
    reply_t e;
    logic   nready;
    nready = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected result, got tuser %b tdata %h", $time, m_tuser, m_tdata);
          errors++;
        end else begin
          e = reply_q.pop_front();
          if (m_tuser !== e.rkind || m_tdata[0] !== e.first || m_tdata[1] !== e.changed ||
              m_tdata[17:2] !== e.chk || m_tdata[33:18] !== e.rword) begin
            $display("%0t: mismatch, expected kind %b first %b changed %b chk %h word %h",
                     $time, e.rkind, e.first, e.changed, e.chk, e.rword);
            $display("%0t:          actual kind %b first %b changed %b chk %h word %h",
                     $time, m_tuser, m_tdata[0], m_tdata[1], m_tdata[17:2], m_tdata[33:18]);
            errors++;
          end
          if (e.rkind == RES_FRAME) n_frames_seen++;
          else n_reads_seen++;
        end
        stall_left = idle_en ? $urandom_range(0, 4) : 0;
        // long hold-off once reads are flowing: the block must back up its input
        if (!held && n_reads_seen == 2) begin
          held = 1'b1;
          hold_left = 300;
        end
      end
      if (hold_left > 0) hold_left--;
      else if (stall_left > 0) stall_left--;
      else nready = 1'b1;
    end
    m_tready <= nready;
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= 3000) begin
      $display("%0t: timeout, %0d results outstanding", $time, reply_q.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // stimulus building
  logic [15:0] frame_words[FRAME_WORDS];
  int n_made = 0;

  task automatic add_item(logic kind, logic [7:0] b, logic [7:0] idx);
    pending_q.push_back('{drain: 1'b0, kind: kind, sbyte: b, ridx: idx});
    n_made++;
  endtask

  task automatic add_drain();
    pending_q.push_back('{drain: 1'b1, kind: KIND_BYTE, sbyte: 8'h0, ridx: 8'h0});
  endtask

  // fill payload (fixed byte or random) and seal with header, checksum, tail
  task automatic make_frame(int fill);
    logic [15:0] acc;
    frame_words[0] = HEAD_WORD0;
    frame_words[1] = HEAD_WORD1;
    acc = HEAD_WORD0 ^ HEAD_WORD1;
    for (int k = 2; k < FRAME_WORDS - 3; k++) begin
      frame_words[k] = (fill < 0) ? 16'($urandom) : {fill[7:0], fill[7:0]};
      acc ^= frame_words[k];
    end
    frame_words[FRAME_WORDS-3] = acc;
    frame_words[FRAME_WORDS-2] = TAIL_WORD0;
    frame_words[FRAME_WORDS-1] = TAIL_WORD1;
  endtask

  // send current frame; corrupt one byte when requested
  task automatic send_frame(logic corrupt);
    int bad;
    logic [7:0] b;
    bad = corrupt ? $urandom_range(0, WIN_BYTES - 1) : -1;
    for (int k = 0; k < WIN_BYTES; k++) begin
      b = k[0] ? frame_words[k/2][7:0] : frame_words[k/2][15:8];
      if (k == bad) b ^= 8'($urandom_range(1, 255));
      add_item(KIND_BYTE, b, 8'($urandom));
    end
  endtask

  task automatic send_reads(int n);
    for (int k = 0; k < n; k++) add_item(KIND_READ, 8'($urandom), 8'($urandom));
  endtask

  initial begin
    int sel;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // noise ahead of the frame: the full window slides until the frame lines up
    repeat (60) add_item(KIND_BYTE, 8'($urandom), 8'($urandom));
    // directed: all-ones payload, reads at both ends and around the checksum
    make_frame(255);
    send_frame(1'b0);
    add_item(KIND_READ, 8'hFF, 8'd0);
    add_item(KIND_READ, 8'h00, 8'd1);
    add_item(KIND_READ, 8'hFF, 8'd253);
    add_item(KIND_READ, 8'h00, 8'd254);
    add_item(KIND_READ, 8'hA5, 8'd255);
    add_item(KIND_READ, 8'h5A, 8'd128);
    add_item(KIND_READ, 8'h00, 8'd127);
    add_item(KIND_READ, 8'hFF, 8'd2);
    repeat (20) add_item(KIND_BYTE, 8'($urandom), 8'($urandom));
    add_drain();

    // random: window bytes mixed with reads of the stored frame
    while (n_made < 650) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        repeat ($urandom_range(1, 12)) add_item(KIND_BYTE, 8'($urandom), 8'($urandom));
      end else begin
        send_reads($urandom_range(1, 8));
      end
      if (sel == 7 && $urandom_range(0, 3) == 0) add_drain();
    end
    send_reads(4);

    wait (pending_q.size() == 0 && !s_tvalid);
    wait (reply_q.size() == 0);
    repeat (300) @(posedge clk);
    $display("tb_top: %0d items sent, %0d frame reports and %0d read replies checked",
             n_sent, n_frames_seen, n_reads_seen);
    if (errors == 0 && reply_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
